[src/aabbpcr_pkg.sv]
// Shared types, codes and helper functions for the box pair collision resolver.
// Used by every module under src; depends on nothing else.
package aabbpcr_pkg;

  localparam int PosW  = 32;
  localparam int SizeW = 31;
  localparam int QW    = 32;             // quotient bits, one divider stage each
  localparam int DivSteps = QW;
  localparam int InW   = 320;
  localparam int OutW  = 136;

  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_X    = 2'd2;

  // Per-request side data that rides alongside the divider.
  typedef struct packed {
    logic signed [PosW-1:0] ax;
    logic signed [PosW-1:0] ay;
    logic signed [PosW-1:0] bx;
    logic signed [PosW-1:0] by;
    logic                   ov;
    logic                   along_y;
    logic                   move;
    logic                   a_gt;
  } carry_t;

  typedef struct packed {
    logic [QW:0]   rem;
    logic [QW-1:0] lo;
  } div_t;

  // One restoring division step: bring in the next dividend bit, subtract if it fits.
  function automatic div_t div_step(input div_t cur, input logic [QW:0] den);
    div_t res;
    logic [QW+1:0] t;
    logic ge;
    t = {cur.rem, cur.lo[QW-1]};
    ge = (t >= {1'b0, den});
    res.rem = ge ? (QW+1)'(t - {1'b0, den}) : t[QW:0];
    res.lo = {cur.lo[QW-2:0], ge};
    return res;
  endfunction

  function automatic logic signed [PosW-1:0] sat32(input logic signed [PosW+1:0] v);
    logic signed [PosW+1:0] hi;
    logic signed [PosW+1:0] lo;
    hi = (PosW+2)'(32'h7fff_ffff);
    lo = ~hi;
    if (v > hi) return hi[PosW-1:0];
    else if (v < lo) return lo[PosW-1:0];
    else return v[PosW-1:0];
  endfunction

endpackage

[src/aabbpcr_front.sv]
// Front stages: distances, overlap test, axis choice, mass shares and products.
// Depends on aabbpcr_pkg.
module aabbpcr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [aabbpcr_pkg::InW-1:0]  in_data,
  output logic                         out_valid,
  output logic [63:0]                  num_a,
  output logic [63:0]                  num_b,
  output logic [aabbpcr_pkg::QW:0]     den,
  output aabbpcr_pkg::carry_t          carry
);
  import aabbpcr_pkg::*;

  logic signed [31:0] in_ax, in_ay, in_bx, in_by;
  logic [30:0] in_wa, in_ha, in_ma, in_wb, in_hb, in_mb;
  logic in_sa, in_sb;

  assign in_ax = in_data[31:0];
  assign in_ay = in_data[63:32];
  assign in_wa = in_data[94:64];
  assign in_ha = in_data[125:95];
  assign in_ma = in_data[156:126];
  assign in_sa = in_data[157];
  assign in_bx = in_data[189:158];
  assign in_by = in_data[221:190];
  assign in_wb = in_data[252:222];
  assign in_hb = in_data[283:253];
  assign in_mb = in_data[314:284];
  assign in_sb = in_data[315];

  // Stage 1: doubled centre distances and size sums.
  logic v1;
  logic signed [31:0] ax1, ay1, bx1, by1;
  logic [32:0] dx2, dy2;
  logic [31:0] sw, sh, ms;
  logic sa1, sb1, mz1;
  logic [30:0] ma1, mb1;

  logic signed [32:0] ddx, ddy;
  logic [31:0] adx, ady;
  always_comb begin
    ddx = 33'(in_ax) - 33'(in_bx);
    ddy = 33'(in_ay) - 33'(in_by);
    adx = ddx[32] ? 32'(-ddx) : ddx[31:0];
    ady = ddy[32] ? 32'(-ddy) : ddy[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      ax1 <= in_ax; ay1 <= in_ay; bx1 <= in_bx; by1 <= in_by;
      dx2 <= {adx, 1'b0};
      dy2 <= {ady, 1'b0};
      sw  <= 32'(in_wa) + 32'(in_wb);
      sh  <= 32'(in_ha) + 32'(in_hb);
      ms  <= 32'(in_ma) + 32'(in_mb);
      mz1 <= (in_ma == '0) && (in_mb == '0);
      ma1 <= in_ma; mb1 <= in_mb;
      sa1 <= in_sa; sb1 <= in_sb;
    end
  end

  // Stage 2: overlap, penetrations, axis, direction and weights.
  logic v2;
  logic [31:0] p2, wfa, wfb, s2;
  carry_t c2;

  logic ov, along_y;
  logic [31:0] px2, py2, pen, wa_n, wb_n, s_n;
  logic signed [31:0] ca, cb;
  carry_t c_n;
  always_comb begin
    ov = (dx2 < {1'b0, sw}) && (dy2 < {1'b0, sh});
    px2 = sw - dx2[31:0];
    py2 = sh - dy2[31:0];
    along_y = px2 > py2;
    pen = along_y ? py2 : px2;
    ca = along_y ? ay1 : ax1;
    cb = along_y ? by1 : bx1;
    // wa_n weights the move of A (the mass of B), wb_n the move of B.
    if (sa1) begin
      wa_n = 32'd0; wb_n = 32'd1; s_n = 32'd1;
    end else if (sb1) begin
      wa_n = 32'd1; wb_n = 32'd0; s_n = 32'd1;
    end else if (mz1) begin
      wa_n = 32'd1; wb_n = 32'd1; s_n = 32'd2;
    end else begin
      wa_n = 32'(mb1); wb_n = 32'(ma1); s_n = ms;
    end
    c_n.ax = ax1; c_n.ay = ay1; c_n.bx = bx1; c_n.by = by1;
    c_n.ov = ov;
    c_n.along_y = along_y;
    c_n.move = ov && (px2 != py2) && (ca != cb);
    c_n.a_gt = ca > cb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      p2 <= pen; wfa <= wa_n; wfb <= wb_n; s2 <= s_n; c2 <= c_n;
    end
  end

  // Stage 3: dividend products with the rounding offset, divisor 2*s.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      num_a <= 64'(p2) * 64'(wfa) + 64'(s2);
      num_b <= 64'(p2) * 64'(wfb) + 64'(s2);
      den   <= {s2, 1'b0};
      carry <= c2;
    end
  end

endmodule

[src/aabbpcr_div_pipe.sv]
// Two pipelined restoring dividers, one quotient bit per stage, for the two moves.
// Depends on aabbpcr_pkg.
module aabbpcr_div_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [63:0]                   num_a,
  input  logic [63:0]                   num_b,
  input  logic [aabbpcr_pkg::QW:0]      den,
  input  aabbpcr_pkg::carry_t           carry_in,
  output logic                          out_valid,
  output logic [aabbpcr_pkg::QW-1:0]    q_a,
  output logic [aabbpcr_pkg::QW-1:0]    q_b,
  output aabbpcr_pkg::carry_t           carry_out
);
  import aabbpcr_pkg::*;

  logic   vld [DivSteps];
  div_t   da  [DivSteps];
  div_t   db  [DivSteps];
  logic [QW:0] dn [DivSteps];
  carry_t cr  [DivSteps];

  // The quotient stays below 2^32, so the upper dividend word is already below
  // the divisor and only the lower 32 bits need steps.
  div_t sa, sb;
  always_comb begin
    sa.rem = {1'b0, num_a[63:32]};
    sa.lo  = num_a[31:0];
    sb.rem = {1'b0, num_b[63:32]};
    sb.lo  = num_b[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DivSteps; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < DivSteps; k++) vld[k] <= vld[k-1];
    end
    if (en) begin
      da[0] <= div_step(sa, den);
      db[0] <= div_step(sb, den);
      dn[0] <= den;
      cr[0] <= carry_in;
      for (int k = 1; k < DivSteps; k++) begin
        da[k] <= div_step(da[k-1], dn[k-1]);
        db[k] <= div_step(db[k-1], dn[k-1]);
        dn[k] <= dn[k-1];
        cr[k] <= cr[k-1];
      end
    end
  end

  assign out_valid = vld[DivSteps-1];
  assign q_a       = da[DivSteps-1].lo;
  assign q_b       = db[DivSteps-1].lo;
  assign carry_out = cr[DivSteps-1];

endmodule

[src/aabbpcr_back.sv]
// Output stage: applies the two moves along the chosen axis and saturates.
// Depends on aabbpcr_pkg.
module aabbpcr_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [aabbpcr_pkg::QW-1:0]   q_a,
  input  logic [aabbpcr_pkg::QW-1:0]   q_b,
  input  aabbpcr_pkg::carry_t          carry,
  output logic                         out_valid,
  output logic [aabbpcr_pkg::OutW-1:0] out_data
);
  import aabbpcr_pkg::*;

  logic signed [PosW+1:0] ca, cb, na, nb;
  logic signed [PosW-1:0] ra, rb;
  logic [1:0] axis;
  logic signed [PosW-1:0] oax, oay, obx, oby;

  always_comb begin
    ca = (PosW+2)'(carry.along_y ? carry.ay : carry.ax);
    cb = (PosW+2)'(carry.along_y ? carry.by : carry.bx);
    if (!carry.move) begin
      na = ca; nb = cb;
    end else if (carry.a_gt) begin
      na = ca + $signed({2'b00, q_a});
      nb = cb - $signed({2'b00, q_b});
    end else begin
      na = ca - $signed({2'b00, q_a});
      nb = cb + $signed({2'b00, q_b});
    end
    ra = sat32(na);
    rb = sat32(nb);
    oax = carry.along_y ? carry.ax : ra;
    oay = carry.along_y ? ra : carry.ay;
    obx = carry.along_y ? carry.bx : rb;
    oby = carry.along_y ? rb : carry.by;
    axis = !carry.move ? AXIS_NONE : (carry.along_y ? AXIS_Y : AXIS_X);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= {5'd0, axis, carry.ov, oby, obx, oay, oax};
    end
  end

endmodule

[src/aabb_pair_collision_resolve.sv]
// Box pair collision resolver: overlap test and minimum-penetration separation.
// An accepted request passes through three front stages, 32 divider stages
// (one quotient bit each) and one output register before its result appears.
// Throughput is one request per cycle; the whole pipeline holds while a result waits.
// Reset (rst, synchronous, active high) clears all valid bits; the data registers are not reset.
module aabb_pair_collision_resolve (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_a_x[31:0] pos_a_y[63:32] width_a[94:64] height_a[125:95] mass_a[156:126]
  // static_a[157] pos_b_x[189:158] pos_b_y[221:190] width_b[252:222]
  // height_b[283:253] mass_b[314:284] static_b[315], zeros above
  input  logic [aabbpcr_pkg::InW-1:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_a_x[31:0] new_a_y[63:32] new_b_x[95:64] new_b_y[127:96] overlap[128]
  // resolve_axis[130:129], zeros above
  output logic [aabbpcr_pkg::OutW-1:0] m_axis_tdata
);
  import aabbpcr_pkg::*;

  // The pipeline moves as a whole. It advances whenever the output register is
  // empty or its result is being taken, so no request is dropped or repeated.
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic        f_valid;
  logic [63:0] f_num_a, f_num_b;
  logic [QW:0] f_den;
  carry_t      f_carry;

  // Front end: distances, overlap, axis choice, weights and the two dividends.
  aabbpcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .out_valid (f_valid),
    .num_a     (f_num_a),
    .num_b     (f_num_b),
    .den       (f_den),
    .carry     (f_carry)
  );

  logic          d_valid;
  logic [QW-1:0] d_q_a, d_q_b;
  carry_t        d_carry;

  // The rounded shares of the penetration come out of a bit-per-stage divider.
  aabbpcr_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num_a     (f_num_a),
    .num_b     (f_num_b),
    .den       (f_den),
    .carry_in  (f_carry),
    .out_valid (d_valid),
    .q_a       (d_q_a),
    .q_b       (d_q_b),
    .carry_out (d_carry)
  );

  // Apply the moves, saturate, and hold the result for the downstream side.
  aabbpcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .q_a       (d_q_a),
    .q_b       (d_q_b),
    .carry     (d_carry),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

[tb/aabb_pair_collision_resolve_tb.sv]
// Testbench for the box pair collision resolver: directed and random box pairs,
// checked against a behavioral predictor. Depends on src/aabbpcr_pkg.sv and the DUT.
module aabb_pair_collision_resolve_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aabbpcr_pkg::*;

  // One box pair as it travels on the request bus.
  typedef struct {
    logic signed [31:0] ax, ay, bx, by;
    logic [30:0] wa, ha, ma, wb, hb, mb;
    logic sa, sb;
  } pair_t;

  typedef struct {
    logic signed [31:0] ax, ay, bx, by;
    logic ov;
    logic [1:0] axis;
  } resolved_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;

  pair_t pending_pairs[$];
  resolved_t expected_positions[$];
  int errors = 0;
  int checked = 0;
  int overlaps_seen = 0;
  int moves_seen = 0;
  int phase = 0;        // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  bit hold_sender = 1'b0;
  longint cycles = 0;

  aabb_pair_collision_resolve u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [InW-1:0] pack_pair(pair_t p);
    return {4'b0, p.sb, p.mb, p.hb, p.wb, p.by, p.bx, p.sa, p.ma, p.ha, p.wa, p.ay, p.ax};
  endfunction

  function automatic logic signed [31:0] clamp_pos(logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Minimum-penetration separation, kept exactly in half-LSB units.
  function automatic resolved_t separate_pair(pair_t p);
    resolved_t r;
    logic [33:0] dx2, dy2, sw, sh, pen2, tot;
    logic [96:0] mva, mvb;
    logic signed [33:0] ca, cb;
    logic along_y;
    r = '{p.ax, p.ay, p.bx, p.by, 1'b0, AXIS_NONE};
    dx2 = 2 * ((p.ax > p.bx) ? 34'(p.ax) - 34'(p.bx) : 34'(p.bx) - 34'(p.ax));
    dy2 = 2 * ((p.ay > p.by) ? 34'(p.ay) - 34'(p.by) : 34'(p.by) - 34'(p.ay));
    sw = 34'(p.wa) + 34'(p.wb);
    sh = 34'(p.ha) + 34'(p.hb);
    if (dx2 < sw && dy2 < sh) begin
      r.ov = 1'b1;
      if (sw - dx2 != sh - dy2) begin
        along_y = (sw - dx2) > (sh - dy2);
        pen2 = along_y ? sh - dy2 : sw - dx2;
        if (p.sa) begin
          mva = 0;
          mvb = (97'(pen2) + 1) >> 1;
        end else if (p.sb) begin
          mva = (97'(pen2) + 1) >> 1;
          mvb = 0;
        end else begin
          tot = 34'(p.ma) + 34'(p.mb);
          if (tot == 0) begin
            mva = (97'(pen2) + 2) / 4;
            mvb = mva;
          end else begin
            mva = (97'(pen2) * p.mb + tot) / (2 * 97'(tot));
            mvb = (97'(pen2) * p.ma + tot) / (2 * 97'(tot));
          end
        end
        ca = along_y ? 34'(p.ay) : 34'(p.ax);
        cb = along_y ? 34'(p.by) : 34'(p.bx);
        if (ca != cb) begin
          if (ca > cb) begin
            ca = ca + 34'(mva);
            cb = cb - 34'(mvb);
          end else begin
            ca = ca - 34'(mva);
            cb = cb + 34'(mvb);
          end
          r.axis = along_y ? AXIS_Y : AXIS_X;
          if (along_y) begin
            r.ay = clamp_pos(ca);
            r.by = clamp_pos(cb);
          end else begin
            r.ax = clamp_pos(ca);
            r.bx = clamp_pos(cb);
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_pos(int span);
    if (span == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [30:0] rand_size(int lim);
    if (lim == 0) return 31'($urandom);
    return 31'($urandom_range(0, lim));
  endfunction

  // Random pair, mostly near each other so that overlaps dominate.
  function automatic pair_t random_pair();
    pair_t p;
    int span, lim;
    case ($urandom_range(0, 9))
      0: begin span = 0; lim = 0; end
      1: begin span = 32'h3fff_ffff; lim = 0; end
      2, 3: begin span = 200; lim = 300; end
      default: begin span = 1 << 20; lim = 1 << 22; end
    endcase
    p.ax = rand_pos(span);
    p.ay = rand_pos(span);
    p.bx = ($urandom_range(0, 7) == 0) ? p.ax : rand_pos(span);
    p.by = rand_pos(span);
    p.wa = rand_size(lim);
    p.ha = rand_size(lim);
    p.wb = rand_size(lim);
    p.hb = ($urandom_range(0, 7) == 0) ? p.wa : rand_size(lim);
    p.ma = ($urandom_range(0, 5) == 0) ? 31'd0 : 31'($urandom);
    p.mb = ($urandom_range(0, 5) == 0) ? 31'd0 : 31'($urandom);
    p.sa = ($urandom_range(0, 4) == 0);
    p.sb = ($urandom_range(0, 4) == 0);
    if (span == 32'h3fff_ffff && $urandom_range(0, 1)) begin
      // Push a box against the edge of the range to exercise saturation.
      p.ax = 32'sh7fff_fff0;
      p.bx = 32'sh7fff_ff00;
      p.wa = 31'h7fff_ffff;
      p.wb = 31'h7fff_ffff;
    end
    return p;
  endfunction

  function automatic pair_t make_pair(int ax, int ay, int bx, int by, int w, int h, int m,
                                      bit sa, bit sb);
    pair_t p;
    p = '{ax, ay, bx, by, 31'(w), 31'(h), 31'(m), 31'(w), 31'(h), 31'(m), sa, sb};
    return p;
  endfunction

  // Appends a pair to the queue the driver sends from.
  task automatic queue_pair(pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %h expected %h", checked, what, got, want);
  endtask

  // Driver: one request per handshake, idling according to the current phase.
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pairs.size() > 0 && !hold_sender &&
            !((phase == 1 || phase == 3) && $urandom_range(0, 99) < (phase == 1 ? 68 : 25)))
        begin
          pair_t p;
          p = pending_pairs.pop_front();
          expected_positions.insert(expected_positions.size(), separate_pair(p));
          s_axis_tdata <= pack_pair(p);
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the result side and check each accepted result in order.
  always @(posedge clk) begin
    if (!rst) begin
      m_axis_tready <= !((phase == 2 || phase == 3) &&
                         $urandom_range(0, 99) < (phase == 2 ? 68 : 25));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_positions.size() == 0) begin
          errors++;
          $display("result with nothing expected: %h", m_axis_tdata);
        end else begin
          resolved_t e;
          e = expected_positions.pop_front();
          if (m_axis_tdata[31:0] !== e.ax) report_mismatch("new_a_x", m_axis_tdata[31:0], e.ax);
          if (m_axis_tdata[63:32] !== e.ay) report_mismatch("new_a_y", m_axis_tdata[63:32], e.ay);
          if (m_axis_tdata[95:64] !== e.bx) report_mismatch("new_b_x", m_axis_tdata[95:64], e.bx);
          if (m_axis_tdata[127:96] !== e.by)
            report_mismatch("new_b_y", m_axis_tdata[127:96], e.by);
          if (m_axis_tdata[128] !== e.ov) report_mismatch("overlap", m_axis_tdata[128], e.ov);
          if (m_axis_tdata[130:129] !== e.axis)
            report_mismatch("resolve_axis", m_axis_tdata[130:129], e.axis);
          if (e.ov) overlaps_seen++;
          if (e.axis != AXIS_NONE) moves_seen++;
          checked++;
        end
      end
    end
  end

  // Watchdog: the slowest correct run is far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[aabb_pair_collision_resolve] ERROR");
      $finish;
    end
  end

  task automatic run_phase(int n);
    repeat (n) queue_pair(random_pair());
    while (pending_pairs.size() > 0) @(posedge clk);
  endtask

  initial begin
    pair_t p;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Directed: separation, touching, equal penetration, equal centres, statics,
    // zero mass, saturation and field extremes.
    queue_pair(make_pair(0, 0, 100, 10, 400, 300, 65536, 0, 0));
    queue_pair(make_pair(0, 0, 200, 0, 400, 400, 65536, 0, 0));
    queue_pair(make_pair(0, 0, 500, 0, 400, 400, 65536, 0, 0));
    queue_pair(make_pair(0, 0, 100, 100, 400, 400, 65536, 0, 0));
    queue_pair(make_pair(0, 0, 0, 10, 400, 400, 65536, 0, 0));
    queue_pair(make_pair(0, 5, 0, 0, 400, 100, 65536, 0, 0));
    queue_pair(make_pair(10, 0, 0, 3, 400, 400, 7, 1, 0));
    queue_pair(make_pair(10, 0, 0, 3, 400, 400, 7, 0, 1));
    queue_pair(make_pair(0, 3, 10, 0, 401, 400, 7, 1, 1));
    queue_pair(make_pair(0, 3, 11, 0, 401, 400, 0, 0, 0));
    queue_pair(make_pair(-2147483648, 0, -2147483647, 1, 2147483647, 2147483647,
                         2147483647, 0, 0));
    queue_pair(make_pair(2147483647, 0, 2147483646, 1, 2147483647, 2147483647,
                         0, 0, 1));
    queue_pair(make_pair(-1, -1, -1, -1, 0, 0, 0, 1, 1));
    p = make_pair(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555, 0, 0, 0, 0, 1);
    p.wa = 31'h5555_5555; p.ha = 31'h2aaa_aaaa; p.ma = 31'h5555_5555;
    queue_pair(p);
    p = make_pair(0, 0, 3, 2, 100, 100, 0, 0, 0);
    p.ma = 31'h7fff_ffff; p.mb = 31'd1;
    queue_pair(p);
    while (pending_pairs.size() > 0) @(posedge clk);
    // Hold the sender until the pipeline drains completely.
    hold_sender = 1'b1;
    while (expected_positions.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    for (int k = 0; k < 4; k++) begin
      phase = k;
      run_phase(110);
    end
    phase = 0;
    run_phase(100);
    phase = 3;
    run_phase(100);
    while (expected_positions.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d box pairs: %0d overlapping, %0d separated along an axis",
             checked, overlaps_seen, moves_seen);
    if (errors == 0) begin
      $display("[aabb_pair_collision_resolve] OK");
    end else begin
      $display("[aabb_pair_collision_resolve] ERROR");
    end
    $finish;
  end
endmodule
